@@ sv/tmic_pkg.sv @@
// ----------------------------------------------------------------------------
// tmic_pkg: shared types and constants of the middle-index contraction engine
// Command and status codes, register indexes, sequencer states, the control
// bundle between sequencer and top level, and parameter defaults.
// ----------------------------------------------------------------------------
package tmic_pkg;

	localparam int MATRIX_DEPTH_DEF   = 256;
	localparam int TENSOR_DEPTH_DEF   = 1024;
	localparam int COEF_FRAC_BITS_DEF = 12;

	localparam int CMD_W     = 3;
	localparam int INDEX_W   = 10;
	localparam int VALUE_W   = 32;
	localparam int COEF_W    = 16;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 11;
	localparam int OUTER_W   = 11;
	localparam int INNER_W   = 5;
	localparam int PROD3_W   = 27;

	localparam logic [CMD_W-1:0] CMD_LOAD_T = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_U = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD_V = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RUN    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_V = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INDEX = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SIZE  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_OUTER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_INNER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_TRAILING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_RESULT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ACCUMULATE    = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_WAIT,
		S_CHK1,
		S_CHK2,
		S_CHK3,
		S_CLEAR,
		S_TERM_RD,
		S_TERM_MUL,
		S_TERM_ACC,
		S_DONE
	} tmic_state_t;

	typedef struct packed {
		logic                mul_en;
		logic                clr_we;
		logic                acc_we;
		logic                resp;
		logic                resp_read;
		logic [STATUS_W-1:0] status;
	} tmic_ctl_t;

endpackage

@@ sv/tmic_req_if.sv @@
// ----------------------------------------------------------------------------
// tmic_req_if: command channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface tmic_req_if import tmic_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic [INDEX_W-1:0]        entry_index;
	logic signed [VALUE_W-1:0] entry_value;

	modport source (output valid, command, entry_index, entry_value, input ready);
	modport sink (input valid, command, entry_index, entry_value, output ready);
endinterface

@@ sv/tmic_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tmic_rsp_if: response channel
// Valid/ready channel carrying one response beat.
// ----------------------------------------------------------------------------
interface tmic_rsp_if import tmic_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] read_value;
	logic [STATUS_W-1:0]       status;

	modport source (output valid, read_value, status, input ready);
	modport sink (input valid, read_value, status, output ready);
endinterface

@@ sv/tmic_mac.sv @@
// ----------------------------------------------------------------------------
// tmic_mac: shared multiply-accumulate unit
// Registered Q4.12 x Q16.16 product, floor shift, saturating add onto V.
// ----------------------------------------------------------------------------
module tmic_mac import tmic_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      mul_en,
	input  logic signed [COEF_W-1:0]  coef,
	input  logic signed [VALUE_W-1:0] src,
	input  logic signed [VALUE_W-1:0] acc,
	output logic signed [VALUE_W-1:0] sum,
	output logic                      sat
);

	localparam int PROD_W = COEF_W + VALUE_W;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] shifted;
	logic signed [PROD_W:0]   sum_w;
	logic                     pos_ovf;
	logic                     neg_ovf;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= PROD_W'(coef) * PROD_W'(src);
		end
	end

	// arithmetic shift gives the floor
	assign shifted = prod_q >>> COEF_FRAC_BITS;
	assign sum_w   = (PROD_W+1)'(acc) + (PROD_W+1)'(shifted);
	assign pos_ovf = !sum_w[PROD_W] && (|sum_w[PROD_W-1:VALUE_W-1]);
	assign neg_ovf = sum_w[PROD_W] && !(&sum_w[PROD_W-1:VALUE_W-1]);
	assign sat     = pos_ovf || neg_ovf;

	always_comb begin
		priority if (pos_ovf) begin
			sum = {1'b0, {(VALUE_W-1){1'b1}}};
		end else if (neg_ovf) begin
			sum = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			sum = sum_w[VALUE_W-1:0];
		end
	end

endmodule

@@ sv/tmic_ctrl.sv @@
// ----------------------------------------------------------------------------
// tmic_ctrl: run sequencer
// Size check, V clearing sweep, a/b/j/c term loop with running addresses,
// and the read-back wait state.
// ----------------------------------------------------------------------------
module tmic_ctrl import tmic_pkg::*; #(
	parameter int MATRIX_DEPTH = MATRIX_DEPTH_DEF,
	parameter int TENSOR_DEPTH = TENSOR_DEPTH_DEF,
	localparam int MA_W = $clog2(MATRIX_DEPTH),
	localparam int TA_W = $clog2(TENSOR_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [OUTER_W-1:0] size_outer,
	input  logic [INNER_W-1:0] size_inner,
	input  logic [OUTER_W-1:0] size_trailing,
	input  logic [INNER_W-1:0] size_result,
	input  logic               transpose_mode,
	input  logic               accumulate_mode,
	input  logic               run_start,
	input  logic               rd_start,
	input  logic               mac_sat,
	output logic               busy,
	output tmic_ctl_t          ctl,
	output logic [MA_W-1:0]    t_addr,
	output logic [TA_W-1:0]    u_addr,
	output logic [TA_W-1:0]    v_addr
);

	localparam int MC_W = MA_W + 1;
	localparam int TC_W = TA_W + 1;
	localparam int JB_W = 2 * INNER_W;
	localparam int AC_W = 2 * OUTER_W;
	localparam int JC_W = INNER_W + OUTER_W;

	tmic_state_t state_q, state_d;

	logic [JB_W-1:0]    jb_q;
	logic [AC_W-1:0]    ac_q;
	logic [JC_W-1:0]    jc_q;
	logic [PROD3_W-1:0] abc_q;
	logic [PROD3_W-1:0] ajc_q;
	logic [TC_W-1:0]    clr_q;
	logic               sat_q;

	logic [OUTER_W-1:0] a_q, c_q;
	logic [INNER_W-1:0] b_q, j_q;
	logic [TC_W-1:0]    u_base_q, v_row_q, v_base_q;
	logic [MC_W-1:0]    t_row_q, t_q;

	logic            size_fail, no_terms, clr_last;
	logic            c_last, j_last, b_last, a_last, term_last;
	logic [MC_W-1:0] tstep_j, tstep_b;
	logic [TC_W-1:0] c_step, jc_step, u_sum, v_sum;

	assign size_fail = (32'(jb_q) > MATRIX_DEPTH) || (32'(abc_q) > TENSOR_DEPTH)
		|| (32'(ajc_q) > TENSOR_DEPTH);
	assign no_terms = (size_outer == '0) || (size_inner == '0)
		|| (size_trailing == '0) || (size_result == '0);
	assign clr_last = ((PROD3_W+1)'(clr_q) + (PROD3_W+1)'(1)) >= (PROD3_W+1)'(ajc_q);

	assign c_last    = (c_q == size_trailing - OUTER_W'(1));
	assign j_last    = (j_q == size_result - INNER_W'(1));
	assign b_last    = (b_q == size_inner - INNER_W'(1));
	assign a_last    = (a_q == size_outer - OUTER_W'(1));
	assign term_last = c_last && j_last && b_last && a_last;

	assign tstep_j = transpose_mode ? MC_W'(1) : MC_W'(size_inner);
	assign tstep_b = transpose_mode ? MC_W'(size_result) : MC_W'(1);
	assign c_step  = TC_W'(size_trailing);
	assign jc_step = TC_W'(jc_q);

	assign u_sum  = u_base_q + TC_W'(c_q);
	assign v_sum  = v_base_q + TC_W'(c_q);
	assign t_addr = t_q[MA_W-1:0];
	assign u_addr = u_sum[TA_W-1:0];
	assign v_addr = (state_q == S_CLEAR) ? clr_q[TA_W-1:0] : v_sum[TA_W-1:0];
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (run_start) begin
					state_d = S_CHK1;
				end else if (rd_start) begin
					state_d = S_RD_WAIT;
				end
			end
			S_RD_WAIT:  state_d = S_IDLE;
			S_CHK1:     state_d = S_CHK2;
			S_CHK2:     state_d = S_CHK3;
			S_CHK3: begin
				priority if (size_fail) begin
					state_d = S_IDLE;
				end else if (!accumulate_mode && ajc_q != '0) begin
					state_d = S_CLEAR;
				end else if (no_terms) begin
					state_d = S_DONE;
				end else begin
					state_d = S_TERM_RD;
				end
			end
			S_CLEAR: begin
				if (clr_last) begin
					state_d = no_terms ? S_DONE : S_TERM_RD;
				end
			end
			S_TERM_RD:  state_d = S_TERM_MUL;
			S_TERM_MUL: state_d = S_TERM_ACC;
			S_TERM_ACC: state_d = term_last ? S_DONE : S_TERM_RD;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.status = STATUS_OK;
		unique case (state_q)
			S_RD_WAIT: begin
				ctl.resp      = 1'b1;
				ctl.resp_read = 1'b1;
			end
			S_CHK3: begin
				if (size_fail) begin
					ctl.resp   = 1'b1;
					ctl.status = STATUS_SIZE;
				end
			end
			S_CLEAR:    ctl.clr_we = 1'b1;
			S_TERM_MUL: ctl.mul_en = 1'b1;
			S_TERM_ACC: ctl.acc_we = 1'b1;
			S_DONE: begin
				ctl.resp   = 1'b1;
				ctl.status = sat_q ? STATUS_SAT : STATUS_OK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (state_q == S_CHK3 && !size_fail) begin
			sat_q <= 1'b0;
		end else if (state_q == S_TERM_ACC && mac_sat) begin
			sat_q <= 1'b1;
		end
	end

	// size products, one multiply level per cycle
	always_ff @(posedge clk) begin
		if (state_q == S_CHK1) begin
			jb_q <= JB_W'(size_result) * JB_W'(size_inner);
			ac_q <= AC_W'(size_outer) * AC_W'(size_trailing);
			jc_q <= JC_W'(size_result) * JC_W'(size_trailing);
		end
		if (state_q == S_CHK2) begin
			abc_q <= PROD3_W'(ac_q) * PROD3_W'(size_inner);
			ajc_q <= PROD3_W'(ac_q) * PROD3_W'(size_result);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CHK3: begin
				clr_q    <= '0;
				a_q      <= '0;
				b_q      <= '0;
				j_q      <= '0;
				c_q      <= '0;
				u_base_q <= '0;
				v_row_q  <= '0;
				v_base_q <= '0;
				t_row_q  <= '0;
				t_q      <= '0;
			end
			S_CLEAR: clr_q <= clr_q + TC_W'(1);
			S_TERM_ACC: begin
				if (!c_last) begin
					c_q <= c_q + OUTER_W'(1);
				end else begin
					c_q <= '0;
					if (!j_last) begin
						j_q      <= j_q + INNER_W'(1);
						t_q      <= t_q + tstep_j;
						v_base_q <= v_base_q + c_step;
					end else begin
						j_q      <= '0;
						u_base_q <= u_base_q + c_step;
						if (!b_last) begin
							b_q      <= b_q + INNER_W'(1);
							t_row_q  <= t_row_q + tstep_b;
							t_q      <= t_row_q + tstep_b;
							v_base_q <= v_row_q;
						end else begin
							// next a: V rows move on by J*C
							b_q      <= '0;
							t_row_q  <= '0;
							t_q      <= '0;
							a_q      <= a_q + OUTER_W'(1);
							v_row_q  <= v_row_q + jc_step;
							v_base_q <= v_row_q + jc_step;
						end
					end
				end
			end
			default: ;
		endcase
	end

endmodule

@@ sv/tensor_middle_index_contraction_top.sv @@
// ----------------------------------------------------------------------------
// tensor_middle_index_contraction_top: middle-index tensor contraction engine
// Holds T, U and V, and computes V[a][j][c] (+)= sum_b T'[j][b] * U[a][b][c].
//
// Use: commands arrive as beats on req (load T, load U, load V, run, read V);
// every command returns exactly one beat on rsp with read_value and status.
// Sizes and modes are set through cfg_we/cfg_index/cfg_data by the user, only
// while idle; the block does not enforce this. Loads, unknown commands and
// out-of-range indexes: response in the cycle after the command beat, one
// command per cycle sustained while rsp.ready stays high. Read V: response
// via the registered V read port, then the response register. Run: size
// check in S_CHK1..S_CHK3, then in overwrite mode a sweep clearing the A*J*C
// V entries, then S_TERM_RD, S_TERM_MUL, S_TERM_ACC for each A*B*J*C term on
// the single shared MAC and V read-modify-write port, then S_DONE reports.
// req.ready stays low for the whole run. A stalled rsp holds its beat; a new
// command is taken only once the response register is empty or draining in
// the same cycle. Reset clears sizes to 1, modes to 0 and the control state;
// the stores are not cleared, so no sweep follows reset.
// ----------------------------------------------------------------------------
module tensor_middle_index_contraction_top import tmic_pkg::*; #(
	parameter int MATRIX_DEPTH   = MATRIX_DEPTH_DEF,
	parameter int TENSOR_DEPTH   = TENSOR_DEPTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	tmic_req_if.sink             req,
	tmic_rsp_if.source           rsp
);

	localparam int MA_W = $clog2(MATRIX_DEPTH);
	localparam int TA_W = $clog2(TENSOR_DEPTH);

	logic [OUTER_W-1:0] size_outer_q, size_trailing_q;
	logic [INNER_W-1:0] size_inner_q, size_result_q;
	logic               transpose_q, accumulate_q;

	logic [COEF_W-1:0]  t_mem [MATRIX_DEPTH];
	logic [VALUE_W-1:0] u_mem [TENSOR_DEPTH];
	logic [VALUE_W-1:0] v_mem [TENSOR_DEPTH];
	logic [COEF_W-1:0]  t_rd_q;
	logic [VALUE_W-1:0] u_rd_q, v_rd_q;

	logic                rsp_valid_q;
	logic [VALUE_W-1:0]  rsp_value_q;
	logic [STATUS_W-1:0] rsp_status_q;

	logic                accept, t_ok, u_ok, imm_resp;
	logic                run_start, rd_start, t_we, u_we, v_load_we, v_we;
	logic [STATUS_W-1:0] imm_status;
	logic [MA_W-1:0]     t_ra, t_wa;
	logic [TA_W-1:0]     u_ra, u_wa, v_ra, v_wa, v_addr;
	logic [VALUE_W-1:0]  v_wd;
	logic signed [VALUE_W-1:0] mac_sum;
	logic                mac_sat, busy;
	tmic_ctl_t           ctl;

	assign req.ready = !busy && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign t_ok = 32'(req.entry_index) < MATRIX_DEPTH;
	assign u_ok = 32'(req.entry_index) < TENSOR_DEPTH;

	always_comb begin
		imm_resp   = accept;
		imm_status = STATUS_OK;
		unique case (req.command)
			CMD_LOAD_T: imm_status = t_ok ? STATUS_OK : STATUS_INDEX;
			CMD_LOAD_U, CMD_LOAD_V: imm_status = u_ok ? STATUS_OK : STATUS_INDEX;
			CMD_RUN: imm_resp = 1'b0;
			CMD_READ_V: begin
				imm_resp   = accept && !u_ok;
				imm_status = STATUS_INDEX;
			end
			default: ;
		endcase
	end

	assign run_start = accept && (req.command == CMD_RUN);
	assign rd_start  = accept && (req.command == CMD_READ_V) && u_ok;
	assign t_we      = accept && (req.command == CMD_LOAD_T) && t_ok;
	assign u_we      = accept && (req.command == CMD_LOAD_U) && u_ok;
	assign v_load_we = accept && (req.command == CMD_LOAD_V) && u_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_outer_q    <= OUTER_W'(1);
			size_inner_q    <= INNER_W'(1);
			size_trailing_q <= OUTER_W'(1);
			size_result_q   <= INNER_W'(1);
			transpose_q     <= 1'b0;
			accumulate_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE_OUTER:    size_outer_q    <= cfg_data[OUTER_W-1:0];
				REG_SIZE_INNER:    size_inner_q    <= cfg_data[INNER_W-1:0];
				REG_SIZE_TRAILING: size_trailing_q <= cfg_data[OUTER_W-1:0];
				REG_SIZE_RESULT:   size_result_q   <= cfg_data[INNER_W-1:0];
				REG_TRANSPOSE:     transpose_q     <= cfg_data[0];
				REG_ACCUMULATE:    accumulate_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tmic_ctrl #(
		.MATRIX_DEPTH (MATRIX_DEPTH),
		.TENSOR_DEPTH (TENSOR_DEPTH)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.size_outer      (size_outer_q),
		.size_inner      (size_inner_q),
		.size_trailing   (size_trailing_q),
		.size_result     (size_result_q),
		.transpose_mode  (transpose_q),
		.accumulate_mode (accumulate_q),
		.run_start       (run_start),
		.rd_start        (rd_start),
		.mac_sat         (mac_sat),
		.busy            (busy),
		.ctl             (ctl),
		.t_addr          (t_ra),
		.u_addr          (u_ra),
		.v_addr          (v_addr)
	);

	tmic_mac #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.mul_en (ctl.mul_en),
		.coef   (t_rd_q),
		.src    (u_rd_q),
		.acc    (v_rd_q),
		.sum    (mac_sum),
		.sat    (mac_sat)
	);

	assign t_wa = MA_W'(req.entry_index);
	assign u_wa = TA_W'(req.entry_index);
	assign v_ra = busy ? v_addr : TA_W'(req.entry_index);
	assign v_we = v_load_we || ctl.clr_we || ctl.acc_we;

	always_comb begin
		priority if (v_load_we) begin
			v_wa = TA_W'(req.entry_index);
			v_wd = req.entry_value;
		end else if (ctl.clr_we) begin
			v_wa = v_addr;
			v_wd = '0;
		end else begin
			v_wa = v_addr;
			v_wd = mac_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			t_mem[t_wa] <= req.entry_value[COEF_W-1:0];
		end
		t_rd_q <= t_mem[t_ra];
	end

	always_ff @(posedge clk) begin
		if (u_we) begin
			u_mem[u_wa] <= req.entry_value;
		end
		u_rd_q <= u_mem[u_ra];
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			v_mem[v_wa] <= v_wd;
		end
		v_rd_q <= v_mem[v_ra];
	end

	// response register: immediate answers on accept, sequenced ones from ctrl
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (imm_resp || ctl.resp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (imm_resp) begin
			rsp_value_q  <= '0;
			rsp_status_q <= imm_status;
		end else if (ctl.resp) begin
			rsp_value_q  <= ctl.resp_read ? v_rd_q : '0;
			rsp_status_q <= ctl.status;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.status     = rsp_status_q;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for the middle-index tensor contraction engine
// Drives load, run and read commands with random idle and stall bursts on
// both channels. A scoreboard mirrors the T, U and V stores, predicts every
// response beat and checks each one in order.
// ----------------------------------------------------------------------------
module testbench;
	import tmic_pkg::*;

	localparam int ITEM_TARGET     = 850;
	localparam int QUIET_TAIL      = 720;
	localparam int STALL_LIMIT     = 20000;
	localparam int HOLD_OFF_CYCLES = 48;
	localparam int SETTLE_CYCLES   = 16;
	localparam longint VALUE_MAX   = 64'sd2147483647;
	localparam longint VALUE_MIN   = -64'sd2147483648;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_READ_V + 1'b1;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = {CMD_W{1'b1}};

	typedef struct packed {
		logic [VALUE_W-1:0]  read_value;
		logic [STATUS_W-1:0] status;
	} rsp_beat_t;

	class contraction_scoreboard;
		bit [COEF_W-1:0]  coef_mem [MATRIX_DEPTH_DEF];
		bit [VALUE_W-1:0] src_mem  [TENSOR_DEPTH_DEF];
		bit [VALUE_W-1:0] res_mem  [TENSOR_DEPTH_DEF];
		bit               sat_flag;
		int unsigned      ext_outer = 1, ext_inner = 1, ext_trailing = 1, ext_result = 1;
		bit               transposed, accumulating;
		rsp_beat_t        expected_q[$];
		int               failures;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_SIZE_OUTER:    ext_outer = data;
				REG_SIZE_INNER:    ext_inner = data[INNER_W-1:0];
				REG_SIZE_TRAILING: ext_trailing = data;
				REG_SIZE_RESULT:   ext_result = data[INNER_W-1:0];
				REG_TRANSPOSE:     transposed = data[0];
				REG_ACCUMULATE:    accumulating = data[0];
				default: ;
			endcase
		endfunction

		// term order a, b, j, c; every add clamps on its own
		function logic [STATUS_W-1:0] contract();
			longint unsigned na, nb, nc, nj, a, b, j, c, ti, vi, ui;
			bit signed [COEF_W-1:0]  cw;
			bit signed [VALUE_W-1:0] uw, vw;
			longint coef, term, sum;
			na = ext_outer;
			nb = ext_inner;
			nc = ext_trailing;
			nj = ext_result;
			if (nj * nb > MATRIX_DEPTH_DEF || na * nb * nc > TENSOR_DEPTH_DEF ||
					na * nj * nc > TENSOR_DEPTH_DEF)
				return STATUS_SIZE;
			sat_flag = 1'b0;
			if (!accumulating)
				for (vi = 0; vi < na * nj * nc; vi++)
					res_mem[vi] = '0;
			for (a = 0; a < na; a++)
				for (b = 0; b < nb; b++)
					for (j = 0; j < nj; j++) begin
						ti = transposed ? b * nj + j : j * nb + b;
						cw = coef_mem[ti];
						coef = cw;
						for (c = 0; c < nc; c++) begin
							vi = (a * nj + j) * nc + c;
							ui = (a * nb + b) * nc + c;
							uw = src_mem[ui];
							vw = res_mem[vi];
							term = (coef * longint'(uw)) >>> COEF_FRAC_BITS_DEF;
							sum = longint'(vw) + term;
							if (sum > VALUE_MAX) begin
								sum = VALUE_MAX;
								sat_flag = 1'b1;
							end else if (sum < VALUE_MIN) begin
								sum = VALUE_MIN;
								sat_flag = 1'b1;
							end
							res_mem[vi] = sum[VALUE_W-1:0];
						end
					end
			return sat_flag ? STATUS_SAT : STATUS_OK;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
				logic [VALUE_W-1:0] val);
			rsp_beat_t e;
			e.read_value = '0;
			e.status = STATUS_OK;
			case (cmd)
				CMD_LOAD_T: begin
					if (idx < MATRIX_DEPTH_DEF) coef_mem[idx] = val[COEF_W-1:0];
					else e.status = STATUS_INDEX;
				end
				CMD_LOAD_U: begin
					if (idx < TENSOR_DEPTH_DEF) src_mem[idx] = val;
					else e.status = STATUS_INDEX;
				end
				CMD_LOAD_V: begin
					if (idx < TENSOR_DEPTH_DEF) res_mem[idx] = val;
					else e.status = STATUS_INDEX;
				end
				CMD_RUN: e.status = contract();
				CMD_READ_V: begin
					if (idx < TENSOR_DEPTH_DEF) e.read_value = res_mem[idx];
					else e.status = STATUS_INDEX;
				end
				default: ;
			endcase
			expected_q.push_back(e);
		endfunction

		function void check_response(logic [VALUE_W-1:0] value, logic [STATUS_W-1:0] status);
			rsp_beat_t e;
			if (expected_q.size() == 0) begin
				failures++;
				$display("%0t: response beat with nothing outstanding: read_value %h status %0d",
					$time, value, status);
				return;
			end
			e = expected_q.pop_front();
			if (value !== e.read_value) begin
				failures++;
				$display("%0t: read_value mismatch: expected %h actual %h",
					$time, e.read_value, value);
			end
			if (status !== e.status) begin
				failures++;
				$display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, status);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	tmic_req_if req();
	tmic_rsp_if rsp();

	tensor_middle_index_contraction_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	contraction_scoreboard sb = new;

	// stimulus-side view: which entries hold data, and the current sizes
	bit          coef_set [MATRIX_DEPTH_DEF];
	bit          src_set  [TENSOR_DEPTH_DEF];
	bit          res_set  [TENSOR_DEPTH_DEF];
	int unsigned cur_a = 1, cur_b = 1, cur_c = 1, cur_j = 1;
	bit          cur_tr, cur_acc;
	int          items_sent;
	bit          idling_on;
	bit          hold_off_request;

	always @(posedge clk) begin
		if (req.valid && req.ready)
			sb.note_command(req.command, req.entry_index, req.entry_value);
		if (rsp.valid && rsp.ready)
			sb.check_response(rsp.read_value, rsp.status);
	end

	initial begin : response_sink
		int unsigned stall;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			stall = 0;
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 4);
			end
			if (stall == 0) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
			else quiet++;
		end
		$display("tensor_middle_index_contraction_top regression: fail");
		$finish;
	end

	task automatic send(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
			logic [VALUE_W-1:0] val);
		req.valid <= 1'b1;
		req.command <= cmd;
		req.entry_index <= idx;
		req.entry_value <= val;
		do @(posedge clk); while (req.ready !== 1'b1);
		if (cmd <= CMD_READ_V) items_sent++;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic [VALUE_W-1:0] draw_value(logic [CMD_W-1:0] cmd);
		logic [VALUE_W-1:0] raw;
		int unsigned shape;
		raw = $urandom;
		shape = $urandom_range(0, 7);
		if (shape == 0) return raw;
		// close to the rails, to provoke clamping
		if (shape == 1) return {raw[31], {20{~raw[31]}}, raw[10:0]};
		if (cmd == CMD_LOAD_T) return {raw[31:16], {2{raw[13]}}, raw[13:0]};
		return {{10{raw[21]}}, raw[21:0]};
	endfunction

	task automatic load_entry(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx);
		send(cmd, idx, draw_value(cmd));
		case (cmd)
			CMD_LOAD_T: if (idx < MATRIX_DEPTH_DEF) coef_set[idx] = 1'b1;
			CMD_LOAD_U: src_set[idx] = 1'b1;
			CMD_LOAD_V: res_set[idx] = 1'b1;
			default: ;
		endcase
	endtask

	function automatic int pick_written_result();
		int unsigned idx;
		repeat (16) begin
			idx = $urandom_range(0, TENSOR_DEPTH_DEF - 1);
			if (res_set[idx]) return idx;
		end
		return -1;
	endfunction

	function automatic bit sizes_fit();
		return cur_j * cur_b <= MATRIX_DEPTH_DEF && cur_a * cur_b * cur_c <= TENSOR_DEPTH_DEF &&
			cur_a * cur_j * cur_c <= TENSOR_DEPTH_DEF;
	endfunction

	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_DAT_W-1:0];
		@(posedge clk);
		sb.set_reg(idx, data[CFG_DAT_W-1:0]);
	endtask

	task automatic configure(int unsigned outer, inner, trailing, result, bit tr, bit acc);
		wait_idle();
		write_reg(REG_SIZE_OUTER, outer);
		write_reg(REG_SIZE_INNER, inner);
		write_reg(REG_SIZE_TRAILING, trailing);
		write_reg(REG_SIZE_RESULT, result);
		write_reg(REG_TRANSPOSE, tr);
		write_reg(REG_ACCUMULATE, acc);
		cfg_we <= 1'b0;
		cur_a = outer;
		cur_b = inner;
		cur_c = trailing;
		cur_j = result;
		cur_tr = tr;
		cur_acc = acc;
	endtask

	// fill whatever the run will touch, run, then read some of V back
	task automatic load_and_contract(int reads);
		int unsigned t_n, u_n, v_n, k;
		int          ri;
		bit          fits;
		fits = sizes_fit();
		t_n = cur_j * cur_b;
		u_n = cur_a * cur_b * cur_c;
		v_n = cur_a * cur_j * cur_c;
		if (fits) begin
			for (k = 0; k < t_n; k++)
				if (!coef_set[k] || $urandom_range(0, 5) == 0) load_entry(CMD_LOAD_T, k);
			for (k = 0; k < u_n; k++)
				if (!src_set[k] || $urandom_range(0, 5) == 0) load_entry(CMD_LOAD_U, k);
			if (cur_acc)
				for (k = 0; k < v_n; k++)
					if (!res_set[k] || $urandom_range(0, 3) == 0) load_entry(CMD_LOAD_V, k);
		end
		send(CMD_RUN, $urandom, $urandom);
		if (fits && !cur_acc)
			for (k = 0; k < v_n; k++)
				res_set[k] = 1'b1;
		repeat (reads) begin
			if (fits && v_n > 0) ri = $urandom_range(0, v_n - 1);
			else ri = pick_written_result();
			if (ri >= 0) send(CMD_READ_V, ri, $urandom);
		end
	endtask

	task automatic issue_noise();
		int ri;
		case ($urandom_range(0, 4))
			0: send(CMD_LOAD_T, $urandom_range(MATRIX_DEPTH_DEF, (1 << INDEX_W) - 1), $urandom);
			1: send($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI), $urandom, $urandom);
			2: load_entry(CMD_LOAD_T, $urandom_range(0, MATRIX_DEPTH_DEF - 1));
			3: load_entry(($urandom_range(0, 1) != 0) ? CMD_LOAD_U : CMD_LOAD_V, $urandom);
			default: begin
				ri = pick_written_result();
				if (ri >= 0) send(CMD_READ_V, ri, $urandom);
			end
		endcase
	endtask

	initial begin : stimulus
		int          k, phase, kind;
		int unsigned a, b, c, j;
		req.valid <= 1'b0;
		req.command <= CMD_LOAD_T;
		req.entry_index <= '0;
		req.entry_value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SIZE_OUTER;
		cfg_data <= '0;
		arst_n <= 1'b0;
		idling_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: a single term per run
		load_entry(CMD_LOAD_T, 0);
		send(CMD_LOAD_T, 0, 32'h0000_7FFF);
		send(CMD_LOAD_T, MATRIX_DEPTH_DEF - 1, 32'hFFFF_8000);
		coef_set[MATRIX_DEPTH_DEF - 1] = 1'b1;
		send(CMD_LOAD_T, MATRIX_DEPTH_DEF, $urandom);
		send(CMD_LOAD_T, (1 << INDEX_W) - 1, $urandom);
		send(CMD_LOAD_U, 0, 32'h7FFF_FFFF);
		send(CMD_LOAD_U, TENSOR_DEPTH_DEF - 1, 32'h8000_0000);
		src_set[0] = 1'b1;
		src_set[TENSOR_DEPTH_DEF - 1] = 1'b1;
		send(CMD_RUN, 0, 0);
		res_set[0] = 1'b1;
		send(CMD_READ_V, 0, 0);
		send(CMD_LOAD_V, TENSOR_DEPTH_DEF - 1, 32'hFFFF_FFFF);
		res_set[TENSOR_DEPTH_DEF - 1] = 1'b1;
		send(CMD_READ_V, TENSOR_DEPTH_DEF - 1, 0);
		for (k = CMD_SPARE_LO; k <= CMD_SPARE_HI; k++)
			send(k[CMD_W-1:0], $urandom, $urandom);
		send(CMD_LOAD_T, 0, 32'h0000_8000);
		send(CMD_RUN, 0, 0);
		send(CMD_READ_V, 0, 0);
		// smallest coefficient times -1: the product shift rounds down to -1
		send(CMD_LOAD_T, 0, 32'h1234_0001);
		send(CMD_LOAD_U, 0, 32'hFFFF_FFFF);
		send(CMD_RUN, 0, 0);
		send(CMD_READ_V, 0, 0);

		// size limits and zero extents
		configure(2047, 31, 2047, 31, 1'b1, 1'b1);
		send(CMD_RUN, $urandom, $urandom);
		configure(1, 16, 1, 17, 1'b0, 1'b0);
		send(CMD_RUN, $urandom, $urandom);
		configure(1025, 0, 1, 1, 1'b0, 1'b0);
		send(CMD_RUN, $urandom, $urandom);
		configure(0, 0, 0, 0, 1'b0, 1'b0);
		send(CMD_RUN, $urandom, $urandom);
		configure(1024, 0, 1, 1, 1'b0, 1'b0);
		send(CMD_RUN, $urandom, $urandom);
		for (k = 0; k < TENSOR_DEPTH_DEF; k++)
			res_set[k] = 1'b1;
		send(CMD_READ_V, TENSOR_DEPTH_DEF - 1, $urandom);
		configure(1, 0, 1024, 1, 1'b0, 1'b1);
		send(CMD_RUN, $urandom, $urandom);
		send(CMD_READ_V, $urandom, $urandom);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 11);
			a = $urandom_range(1, 4);
			b = $urandom_range(1, 4);
			c = $urandom_range(1, 4);
			j = $urandom_range(1, 4);
			if (phase == 0) begin
				a = 1;
				b = 16;
				c = 1;
				j = 16;
			end else if (kind == 0) begin
				a = 1;
				b = $urandom_range(8, 16);
				c = $urandom_range(1, 2);
				j = $urandom_range(8, 16);
			end else if (kind == 1) begin
				a = $urandom_range(1, 2);
				b = $urandom_range(1, 2);
				c = $urandom_range(8, 32);
				j = $urandom_range(1, 3);
			end else if (kind == 2) begin
				if ($urandom_range(0, 1) != 0) begin
					a = $urandom_range(TENSOR_DEPTH_DEF + 1, 2047);
					c = $urandom_range(1, 2047);
				end else begin
					b = $urandom_range(17, 31);
					j = $urandom_range(17, 31);
				end
			end else if (kind == 3) begin
				case ($urandom_range(0, 3))
					0: a = 0;
					1: b = 0;
					2: c = 0;
					default: j = 0;
				endcase
			end
			configure(a, b, c, j, $urandom_range(0, 1), $urandom_range(0, 1));
			idling_on = items_sent < QUIET_TAIL && $urandom_range(0, 3) != 0;
			if (phase == 0) begin
				// long receiver hold-off while the full matrix is being loaded
				idling_on = 1'b1;
				hold_off_request = 1'b1;
			end
			repeat ($urandom_range(2, 4)) begin
				repeat ($urandom_range(0, 3)) issue_noise();
				load_and_contract($urandom_range(1, 4));
			end
			phase++;
		end

		idling_on = 1'b0;
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("tensor_middle_index_contraction_top regression: pass");
		else
			$display("tensor_middle_index_contraction_top regression: fail");
		$finish;
	end
endmodule
